// File: hw/rtl/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Widths, stage counts and shared types of the quaternion point rotator.
// ----------------------------------------------------------------------------
package qpr_pkg;

  localparam int QW        = 16;            // quaternion component, Q2.14
  localparam int VW        = 32;            // point coordinate, Q16.16
  localparam int FRAC      = 14;            // fraction bits dropped per product
  localparam int SQW       = 2 * QW - 1;    // one square, unsigned
  localparam int M2W       = SQW + 2;       // sum of four squares
  localparam int NW        = M2W + 4;       // sqrt operand, mag2 * 16
  localparam int SRW       = NW + 1;        // sqrt partial root
  localparam int SQ_STEPS  = (NW + 1) / 2;  // root bits
  localparam int MAGW      = SQ_STEPS;      // magnitude, 16 fraction bits
  localparam int DIV_STEPS = 33;            // quotient bits of 2^32 / mag
  localparam int RECW      = 31;            // reciprocal, mag is at least 4
  localparam int RFRAC     = 16;            // reciprocal scaling shift
  localparam int CJW       = QW + 1;        // negated component
  localparam int RPW       = CJW + RECW + 1;
  localparam int INVW      = 18;            // inverse component, Q.14
  localparam int P1W       = INVW + VW;
  localparam int S1W       = P1W + 2;
  localparam int TW        = S1W - FRAC;
  localparam int P2W       = TW + INVW;
  localparam int S2W       = P2W + 2;
  localparam int FW        = S2W - FRAC;

  localparam logic [VW-1:0] OUT_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] OUT_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic                 opcode;
    logic [3:0][QW-1:0]   q;
    logic [2:0][VW-1:0]   v;
  } side_t;

  typedef struct packed {
    logic [VW-1:0] x;
    logic [VW-1:0] y;
    logic [VW-1:0] z;
    logic          sat;
  } res_t;

endpackage

// File: hw/rtl/quaternion_point_rotator.sv
// ----------------------------------------------------------------------------
// quaternion_point_rotator
// Rotates a Q16.16 point by a Q2.14 quaternion, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake               | word
//  input   | in_valid_i / in_ready_o | opcode, quat_x/y/z/w, vec_x/y/z
//  output  | out_valid_o/out_ready_i | out_x/y/z, saturated
//
//  One word per cycle in and out while the sink is ready. The pipe depth is
//  set by the 20-stage square root (load plus 19 root bits) and the 33-stage
//  reciprocal divider.
//  One stall flag freezes the whole pipe; a skid register behind the output
//  register takes the word that is in flight when the sink stalls.
//  Reset clears valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_point_rotator
  import qpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic signed [QW-1:0] quat_x_i,
  input  logic signed [QW-1:0] quat_y_i,
  input  logic signed [QW-1:0] quat_z_i,
  input  logic signed [QW-1:0] quat_w_i,
  input  logic signed [VW-1:0] vec_x_i,
  input  logic signed [VW-1:0] vec_y_i,
  input  logic signed [VW-1:0] vec_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [VW-1:0] out_x_o,
  output logic signed [VW-1:0] out_y_o,
  output logic signed [VW-1:0] out_z_o,
  output logic                 saturated_o
);

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic adv;

  // input stage
  logic  in_v_q;
  side_t in_side_q;

  // squares
  logic            sq_v_q;
  side_t           sq_side_q;
  logic [SQW-1:0]  sq_q [4];
  logic [M2W-1:0]  mag2;

  // square root
  logic [SQ_STEPS:0] sr_v_q;
  side_t             sr_side_q [SQ_STEPS+1];
  logic [NW-1:0]     sr_n_q    [SQ_STEPS+1];
  logic [SRW-1:0]    sr_r_q    [SQ_STEPS+1];
  logic [NW-1:0]     sr_n_d    [SQ_STEPS];
  logic [SRW-1:0]    sr_r_d    [SQ_STEPS];

  // reciprocal
  logic [DIV_STEPS-1:0] dv_v_q;
  side_t                dv_side_q [DIV_STEPS];
  logic [MAGW-1:0]      dv_r_q    [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_quo_q  [DIV_STEPS];
  logic [MAGW-1:0]      dv_mag_q  [DIV_STEPS];
  logic [MAGW-1:0]      dv_ri     [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_qi     [DIV_STEPS];
  logic [MAGW-1:0]      dv_mi     [DIV_STEPS];
  logic [MAGW-1:0]      dv_r_d    [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_quo_d  [DIV_STEPS];

  // inverse
  logic                   iv_v_q;
  side_t                  iv_side_q;
  logic signed [INVW-1:0] iv_inv_q [4];
  logic signed [INVW-1:0] iv_inv_d [4];

  // first product
  logic                   h1p_v_q;
  logic signed [INVW-1:0] h1_a [4];
  logic signed [INVW-1:0] h1_b [4];
  logic signed [P1W-1:0]  p1_d [4][3];
  logic signed [P1W-1:0]  p1_q [4][3];
  logic signed [INVW-1:0] h1p_b_q [4];
  logic                   h1a_v_q;
  logic signed [S1W-2:0]  h1a_s_q [4];
  logic signed [P1W-1:0]  h1a_c_q [4];
  logic signed [INVW-1:0] h1a_b_q [4];
  logic                   h1b_v_q;
  logic signed [TW-1:0]   t_q [4];
  logic signed [INVW-1:0] h1b_b_q [4];

  // second product
  logic                   h2p_v_q;
  logic signed [P2W-1:0]  p2_d [3][4];
  logic signed [P2W-1:0]  p2_q [3][4];
  logic                   h2a_v_q;
  logic signed [S2W-2:0]  h2a_a_q [3];
  logic signed [S2W-2:0]  h2a_b_q [3];
  logic                   h2b_v_q;
  logic signed [FW-1:0]   f_q [3];

  // output
  logic [VW-1:0] res_c [3];
  logic [2:0]    res_s;
  res_t          res;
  logic          out_v_q, skid_v_q;
  res_t          out_q, skid_q;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      sq_v_q  <= 1'b0;
      sr_v_q  <= '0;
      dv_v_q  <= '0;
      iv_v_q  <= 1'b0;
      h1p_v_q <= 1'b0;
      h1a_v_q <= 1'b0;
      h1b_v_q <= 1'b0;
      h2p_v_q <= 1'b0;
      h2a_v_q <= 1'b0;
      h2b_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q  <= in_valid_i;
      sq_v_q  <= in_v_q;
      sr_v_q  <= {sr_v_q[SQ_STEPS-1:0], sq_v_q};
      dv_v_q  <= {dv_v_q[DIV_STEPS-2:0], sr_v_q[SQ_STEPS]};
      iv_v_q  <= dv_v_q[DIV_STEPS-1];
      h1p_v_q <= iv_v_q;
      h1a_v_q <= h1p_v_q;
      h1b_v_q <= h1a_v_q;
      h2p_v_q <= h1b_v_q;
      h2a_v_q <= h2p_v_q;
      h2b_v_q <= h2a_v_q;
    end
  end

  // ---------------------------------------------------------------- datapath
  assign mag2 = M2W'(sq_q[0]) + M2W'(sq_q[1]) + M2W'(sq_q[2]) + M2W'(sq_q[3]);

  always_comb begin
    logic [SRW-1:0] bitv;
    logic [SRW-1:0] trial;
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv  = SRW'(1) << (2 * (SQ_STEPS - 1 - k));
      trial = sr_r_q[k] + bitv;
      if ({1'b0, sr_n_q[k]} >= trial) begin
        sr_n_d[k] = NW'({1'b0, sr_n_q[k]} - trial);
        sr_r_d[k] = (sr_r_q[k] >> 1) + bitv;
      end else begin
        sr_n_d[k] = sr_n_q[k];
        sr_r_d[k] = sr_r_q[k] >> 1;
      end
    end
  end

  // dividend is 2^32: its only set bit enters at the first step
  always_comb begin
    logic [MAGW:0] rs;
    dv_ri[0] = '0;
    dv_qi[0] = '0;
    dv_mi[0] = sr_r_q[SQ_STEPS][MAGW-1:0];
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_ri[k] = dv_r_q[k-1];
      dv_qi[k] = dv_quo_q[k-1];
      dv_mi[k] = dv_mag_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      rs = {dv_ri[k], (k == 0)};
      if (rs >= {1'b0, dv_mi[k]}) begin
        dv_r_d[k]   = MAGW'(rs - {1'b0, dv_mi[k]});
        dv_quo_d[k] = {dv_qi[k][DIV_STEPS-2:0], 1'b1};
      end else begin
        dv_r_d[k]   = rs[MAGW-1:0];
        dv_quo_d[k] = {dv_qi[k][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic signed [CJW-1:0] cj;
    logic signed [RPW-1:0] prod;
    logic [RECW-1:0]       recip;
    recip = dv_quo_q[DIV_STEPS-1][RECW-1:0];
    for (int i = 0; i < 4; i++) begin
      if (i == 3) cj = CJW'($signed(dv_side_q[DIV_STEPS-1].q[i]));
      else        cj = -CJW'($signed(dv_side_q[DIV_STEPS-1].q[i]));
      prod = cj * $signed({1'b0, recip});
      if (dv_mag_q[DIV_STEPS-1] == '0) iv_inv_d[i] = INVW'(cj);
      else                             iv_inv_d[i] = prod[INVW+RFRAC-1:RFRAC];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h1_a[i] = iv_side_q.opcode ? iv_inv_q[i] : INVW'($signed(iv_side_q.q[i]));
      h1_b[i] = iv_side_q.opcode ? INVW'($signed(iv_side_q.q[i])) : iv_inv_q[i];
    end
    for (int c = 0; c < 3; c++) begin
      p1_d[c][0] = h1_a[3]      * $signed(iv_side_q.v[c]);
      p1_d[c][1] = h1_a[NXT[c]] * $signed(iv_side_q.v[PRV[c]]);
      p1_d[c][2] = h1_a[PRV[c]] * $signed(iv_side_q.v[NXT[c]]);
      p1_d[3][c] = h1_a[c]      * $signed(iv_side_q.v[c]);
    end
    for (int c = 0; c < 3; c++) begin
      p2_d[c][0] = t_q[c]      * h1b_b_q[3];
      p2_d[c][1] = t_q[3]      * h1b_b_q[c];
      p2_d[c][2] = t_q[NXT[c]] * h1b_b_q[PRV[c]];
      p2_d[c][3] = t_q[PRV[c]] * h1b_b_q[NXT[c]];
    end
  end

  always_comb begin
    logic [FW-VW:0] hi;
    for (int c = 0; c < 3; c++) begin
      hi = f_q[c][FW-1:VW-1];
      res_s[c] = !((&hi) || !(|hi));
      if (!res_s[c])    res_c[c] = f_q[c][VW-1:0];
      else if (hi[FW-VW]) res_c[c] = OUT_MIN;
      else              res_c[c] = OUT_MAX;
    end
    res.x   = res_c[0];
    res.y   = res_c[1];
    res.z   = res_c[2];
    res.sat = |res_s;
  end

  always_ff @(posedge clk_i) begin
    logic signed [S1W-1:0] s1;
    logic signed [S2W-1:0] s2;
    if (adv) begin
      in_side_q.opcode <= opcode_i;
      in_side_q.q      <= {quat_w_i, quat_z_i, quat_y_i, quat_x_i};
      in_side_q.v      <= {vec_z_i, vec_y_i, vec_x_i};

      sq_side_q <= in_side_q;
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= SQW'($signed(in_side_q.q[i]) * $signed(in_side_q.q[i]));
      end

      sr_side_q[0] <= sq_side_q;
      sr_n_q[0]    <= {mag2, 4'b0000};
      sr_r_q[0]    <= '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sr_side_q[k+1] <= sr_side_q[k];
        sr_n_q[k+1]    <= sr_n_d[k];
        sr_r_q[k+1]    <= sr_r_d[k];
      end

      dv_side_q[0] <= sr_side_q[SQ_STEPS];
      for (int k = 1; k < DIV_STEPS; k++) dv_side_q[k] <= dv_side_q[k-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_r_q[k]   <= dv_r_d[k];
        dv_quo_q[k] <= dv_quo_d[k];
        dv_mag_q[k] <= dv_mi[k];
      end

      iv_side_q <= dv_side_q[DIV_STEPS-1];
      iv_inv_q  <= iv_inv_d;

      p1_q    <= p1_d;
      h1p_b_q <= h1_b;

      for (int c = 0; c < 4; c++) begin
        if (c == 3) h1a_s_q[c] <= -(S1W-1)'(p1_q[c][0]) - (S1W-1)'(p1_q[c][1]);
        else        h1a_s_q[c] <= (S1W-1)'(p1_q[c][0]) + (S1W-1)'(p1_q[c][1]);
        h1a_c_q[c] <= p1_q[c][2];
      end
      h1a_b_q <= h1p_b_q;

      for (int c = 0; c < 4; c++) begin
        s1 = S1W'(h1a_s_q[c]) - S1W'(h1a_c_q[c]);
        t_q[c] <= s1[S1W-1:FRAC];
      end
      h1b_b_q <= h1a_b_q;

      p2_q <= p2_d;

      for (int c = 0; c < 3; c++) begin
        h2a_a_q[c] <= (S2W-1)'(p2_q[c][0]) + (S2W-1)'(p2_q[c][1]);
        h2a_b_q[c] <= (S2W-1)'(p2_q[c][2]) - (S2W-1)'(p2_q[c][3]);
      end

      for (int c = 0; c < 3; c++) begin
        s2 = S2W'(h2a_a_q[c]) + S2W'(h2a_b_q[c]);
        f_q[c] <= s2[S2W-1:FRAC];
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) skid_v_q <= 1'b0;
    end else if (h2b_v_q) begin
      if (!out_v_q || out_ready_i) out_v_q  <= 1'b1;
      else                         skid_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) out_q <= skid_q;
    end else if (h2b_v_q) begin
      if (!out_v_q || out_ready_i) out_q  <= res;
      else                         skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_x_o     = out_q.x;
  assign out_y_o     = out_q.y;
  assign out_z_o     = out_q.z;
  assign saturated_o = out_q.sat;

endmodule

// File: hw/rtl/qpr_checker.sv
// ----------------------------------------------------------------------------
// qpr_checker
// Port-level checks on the quaternion point rotator.
// ----------------------------------------------------------------------------
module qpr_checker
  import qpr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 opcode_i,
  input logic signed [QW-1:0] quat_x_i,
  input logic signed [QW-1:0] quat_y_i,
  input logic signed [QW-1:0] quat_z_i,
  input logic signed [QW-1:0] quat_w_i,
  input logic signed [VW-1:0] vec_x_i,
  input logic signed [VW-1:0] vec_y_i,
  input logic signed [VW-1:0] vec_z_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic signed [VW-1:0] out_x_o,
  input logic signed [VW-1:0] out_y_o,
  input logic signed [VW-1:0] out_z_o,
  input logic                 saturated_o
);

  // input side only stalls while a word sits in the skid register
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      out_x_o == OUT_MAX || out_x_o == OUT_MIN ||
      out_y_o == OUT_MAX || out_y_o == OUT_MIN ||
      out_z_o == OUT_MAX || out_z_o == OUT_MIN)
    else $error("saturated flag without a clipped component");

  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("output word right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_x_o) && $stable(out_y_o) &&
      $stable(out_z_o) && $stable(saturated_o))
    else $error("output word changed while stalled");

endmodule

bind quaternion_point_rotator qpr_checker u_qpr_checker (.*);
